@@ hw/rtl/rcts_pkg.sv @@
// Shared types and constants for the raycast column texture shader.
// Depends on nothing; every other file of the block but rcts_ram imports it.
package rcts_pkg;

   localparam int SCREEN_HEIGHT   = 512;
   localparam int TEX_MAX_DIM_DEF = 64;
   localparam int STORE_DEPTH     = 4096;
   localparam int ADDR_W          = 12;
   localparam int COLOR_W         = 32;
   localparam int COL_W           = 10;
   localparam int ROW_W           = 9;
   localparam int SPAN_END_W      = 10;
   localparam int FRAC_W          = 16;
   localparam int LH_W            = 14;
   localparam int CFG_DIM_W       = 7;
   localparam int CSR_IDX_W       = 2;
   localparam int NUM_W           = 16;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [NUM_W-1:0] HALF_SCREEN = NUM_W'(SCREEN_HEIGHT / 2);

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_SHADE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REGION_CEILING = 2'd0,
      REGION_WALL    = 2'd1,
      REGION_FLOOR   = 2'd2
   } region_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CEILING_COLOR = 2'd0,
      CSR_FLOOR_COLOR   = 2'd1,
      CSR_TEX_WIDTH     = 2'd2,
      CSR_TEX_HEIGHT    = 2'd3
   } csr_index_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [ADDR_W-1:0]      texel_index;
      logic [COLOR_W-1:0]     texel_color;
      logic [COL_W-1:0]       column;
      logic [ROW_W-1:0]       row;
      logic [FRAC_W-1:0]      wall_frac;
      logic                   hit_side;
      logic                   dir_x_positive;
      logic                   dir_y_negative;
      logic [LH_W-1:0]        wall_height;
      logic [ROW_W-1:0]       span_start;
      logic [SPAN_END_W-1:0]  span_end;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]    out_column;
      logic [ROW_W-1:0]    out_row;
      logic [COLOR_W-1:0]  pixel_color;
      region_type          region;
   } rsp_type;

   // What travels down the whole back pipeline
   typedef struct packed {
      cmd_type             cmd;
      logic [ADDR_W-1:0]   texel_index;
      logic [COLOR_W-1:0]  texel_color;
      logic [COL_W-1:0]    column;
      logic [ROW_W-1:0]    row;
      region_type          region;
   } item_type;

   // Classified item handed from the front to the back through the queue
   typedef struct packed {
      item_type            item;
      logic [FRAC_W-1:0]   wall_frac;
      logic                hit_side;
      logic                dir_x_positive;
      logic                dir_y_negative;
      logic                neg;
      logic                sat;
      logic [LH_W-1:0]     nlo;
      logic [LH_W-1:0]     lh;
   } job_type;

endpackage

@@ hw/rtl/rcts_if.sv @@
// Valid/ready channels of the shader: draw/load requests in, shaded pixels out.
// Depends on rcts_pkg for the payload types.
interface rcts_req_if;
   import rcts_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rcts_rsp_if;
   import rcts_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/rcts_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// Stand-alone; used for the texture store.
module rcts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/rcts_queue.sv @@
// Short job queue between the front and back parts of the shader.
// Depends on rcts_pkg for job_type and the queue depth.
module rcts_queue import rcts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   job_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full  = (int'(count_ff) == QUEUE_DEPTH);
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

endmodule

@@ hw/rtl/rcts_front.sv @@
// Front part: accepts request beats, classifies the row against the wall span
// and forms the texel-row numerator. Depends on rcts_pkg and rcts_if.
module rcts_front import rcts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   rcts_req_if.sink req_if,
   input  logic    q_full,
   output logic    q_push,
   output job_type q_job
);

   logic             front_valid_ff;
   job_type          job_ff, job_in;
   logic [LH_W-1:0]  lh_eff;
   logic [NUM_W-1:0] num;

   always_comb begin
      // a zero height acts as one
      lh_eff = (req_if.payload.wall_height == '0) ? LH_W'(1) : req_if.payload.wall_height;
      num = NUM_W'(req_if.payload.row) - HALF_SCREEN + NUM_W'(lh_eff >> 1);

      job_in.item.cmd         = req_if.payload.cmd;
      job_in.item.texel_index = req_if.payload.texel_index;
      job_in.item.texel_color = req_if.payload.texel_color;
      job_in.item.column      = req_if.payload.column;
      job_in.item.row         = req_if.payload.row;
      if (req_if.payload.row < req_if.payload.span_start) begin
         job_in.item.region = REGION_CEILING;
      end else if (SPAN_END_W'(req_if.payload.row) < req_if.payload.span_end) begin
         job_in.item.region = REGION_WALL;
      end else begin
         job_in.item.region = REGION_FLOOR;
      end

      job_in.wall_frac      = req_if.payload.wall_frac;
      job_in.hit_side       = req_if.payload.hit_side;
      job_in.dir_x_positive = req_if.payload.dir_x_positive;
      job_in.dir_y_negative = req_if.payload.dir_y_negative;
      // below zero clamps to texel row 0; at or past the height clamps to the last row
      job_in.neg = num[NUM_W-1];
      job_in.sat = !num[NUM_W-1] && (num >= NUM_W'(lh_eff));
      job_in.nlo = num[LH_W-1:0];
      job_in.lh  = lh_eff;
   end

   assign req_if.ready = !front_valid_ff || !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         front_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         job_ff <= job_in;
      end
   end

   assign q_push = front_valid_ff && !q_full;
   assign q_job  = job_ff;

endmodule

@@ hw/rtl/rcts_back.sv @@
// Back part: texel column, pipelined texel-row division, store address,
// texture store access and the result register. Depends on rcts_pkg, rcts_if, rcts_ram.
module rcts_back import rcts_pkg::*; #(
   parameter int TEX_MAX_DIM = TEX_MAX_DIM_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  job_type                            q_head,
   output logic                               q_pop,
   input  logic [$clog2(TEX_MAX_DIM+1)-1:0]   tw,
   input  logic [$clog2(TEX_MAX_DIM+1)-1:0]   th,
   input  logic [COLOR_W-1:0]                 ceiling_color,
   input  logic [COLOR_W-1:0]                 floor_color,
   rcts_rsp_if.source                         rsp_if
);

   localparam int DIM_W = $clog2(TEX_MAX_DIM + 1);
   localparam int QB    = (TEX_MAX_DIM > 1) ? $clog2(TEX_MAX_DIM) : 1;
   localparam int RW    = LH_W + QB;
   localparam int TXP_W = FRAC_W + DIM_W;
   localparam int NP_W  = LH_W + DIM_W;
   localparam int AP_W  = 2 * DIM_W + 1;

   logic en;

   // queue output stage
   logic    s0_valid_ff;
   job_type s0_job_ff;

   // stage 0 holds the product, stages 1..QB one quotient bit each
   logic             st_valid_ff [QB+1];
   logic             st_valid_in [QB+1];
   item_type         st_item_ff  [QB+1];
   item_type         st_item_in  [QB+1];
   logic             st_neg_ff   [QB+1];
   logic             st_neg_in   [QB+1];
   logic             st_sat_ff   [QB+1];
   logic             st_sat_in   [QB+1];
   logic [LH_W-1:0]  st_lh_ff    [QB+1];
   logic [LH_W-1:0]  st_lh_in    [QB+1];
   logic [RW-1:0]    st_rem_ff   [QB+1];
   logic [RW-1:0]    st_rem_in   [QB+1];
   logic [QB-1:0]    st_q_ff     [QB+1];
   logic [QB-1:0]    st_q_in     [QB+1];
   logic [DIM_W-1:0] st_tx_ff    [QB+1];
   logic [DIM_W-1:0] st_tx_in    [QB+1];

   logic [TXP_W-1:0] tx_prod;
   logic [DIM_W-1:0] tx_raw;
   logic [NP_W-1:0]  n_prod;
   logic [RW-1:0]    div_val [QB+1];
   logic             div_ge  [QB+1];

   // address stage
   logic              a_valid_ff;
   item_type          a_item_ff;
   logic [ADDR_W-1:0] a_addr_ff, a_addr_in;
   logic [DIM_W-1:0]  ty;
   logic [AP_W-1:0]   addr_prod;

   // result stage
   logic              out_valid_ff;
   item_type          out_item_ff;
   logic              ram_we, ram_re;
   logic [COLOR_W-1:0] ram_rdata;

   // the whole back pipeline holds while a result waits
   assign en    = !out_valid_ff || rsp_if.ready;
   assign q_pop = en && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= !q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s0_job_ff <= q_head;
      end
   end

   always_comb begin
      tx_prod = TXP_W'(s0_job_ff.wall_frac) * TXP_W'(tw);
      tx_raw  = tx_prod[TXP_W-1:FRAC_W];
      n_prod  = NP_W'(s0_job_ff.nlo) * NP_W'(th);

      st_valid_in[0] = s0_valid_ff;
      st_item_in[0]  = s0_job_ff.item;
      st_neg_in[0]   = s0_job_ff.neg;
      st_sat_in[0]   = s0_job_ff.sat;
      st_lh_in[0]    = s0_job_ff.lh;
      st_rem_in[0]   = RW'(n_prod);
      st_q_in[0]     = '0;
      // mirror for an x-side hit looking +x or a y-side hit looking -y
      if ((!s0_job_ff.hit_side && s0_job_ff.dir_x_positive) ||
          (s0_job_ff.hit_side && s0_job_ff.dir_y_negative)) begin
         st_tx_in[0] = tw - tx_raw - 1'b1;
      end else begin
         st_tx_in[0] = tx_raw;
      end
      div_val[0] = '0;
      div_ge[0]  = 1'b0;

      // restoring division, most significant quotient bit first
      for (int j = 1; j <= QB; j++) begin
         div_val[j]     = RW'(st_lh_ff[j-1]) << (QB - j);
         div_ge[j]      = st_rem_ff[j-1] >= div_val[j];
         st_valid_in[j] = st_valid_ff[j-1];
         st_item_in[j]  = st_item_ff[j-1];
         st_neg_in[j]   = st_neg_ff[j-1];
         st_sat_in[j]   = st_sat_ff[j-1];
         st_lh_in[j]    = st_lh_ff[j-1];
         st_tx_in[j]    = st_tx_ff[j-1];
         st_rem_in[j]   = div_ge[j] ? st_rem_ff[j-1] - div_val[j] : st_rem_ff[j-1];
         st_q_in[j]     = st_q_ff[j-1];
         st_q_in[j][QB-j] = div_ge[j];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QB; k++) begin
         if (reset) begin
            st_valid_ff[k] <= 1'b0;
         end else if (en) begin
            st_valid_ff[k] <= st_valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QB; k++) begin
         if (en) begin
            st_item_ff[k] <= st_item_in[k];
            st_neg_ff[k]  <= st_neg_in[k];
            st_sat_ff[k]  <= st_sat_in[k];
            st_lh_ff[k]   <= st_lh_in[k];
            st_rem_ff[k]  <= st_rem_in[k];
            st_q_ff[k]    <= st_q_in[k];
            st_tx_ff[k]   <= st_tx_in[k];
         end
      end
   end

   always_comb begin
      if (st_neg_ff[QB]) begin
         ty = '0;
      end else if (st_sat_ff[QB]) begin
         ty = th - 1'b1;
      end else begin
         ty = DIM_W'(st_q_ff[QB]);
      end
      // address wraps to the store size
      addr_prod = AP_W'(ty) * AP_W'(tw) + AP_W'(st_tx_ff[QB]);
      a_addr_in = ADDR_W'(addr_prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= st_valid_ff[QB];
         out_valid_ff <= a_valid_ff && (a_item_ff.cmd == CMD_SHADE);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_item_ff   <= st_item_ff[QB];
         a_addr_ff   <= a_addr_in;
         out_item_ff <= a_item_ff;
      end
   end

   // loads and wall reads meet the store at one stage, so order is kept
   assign ram_we = en && a_valid_ff && (a_item_ff.cmd == CMD_LOAD);
   assign ram_re = en && a_valid_ff && (a_item_ff.cmd == CMD_SHADE) &&
                   (a_item_ff.region == REGION_WALL);

   rcts_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (a_item_ff.texel_index),
      .wdata (a_item_ff.texel_color),
      .re    (ram_re),
      .raddr (a_addr_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp_if.valid              = out_valid_ff;
      rsp_if.payload.out_column = out_item_ff.column;
      rsp_if.payload.out_row    = out_item_ff.row;
      rsp_if.payload.region     = out_item_ff.region;
      case (out_item_ff.region)
         REGION_CEILING: rsp_if.payload.pixel_color = ceiling_color;
         REGION_WALL:    rsp_if.payload.pixel_color = ram_rdata;
         default:        rsp_if.payload.pixel_color = floor_color;
      endcase
   end

endmodule

@@ hw/rtl/raycast_column_texture_shader.sv @@
// Top level of the raycast column texture shader: configuration registers,
// front classifier, job queue and back pipeline. Depends on rcts_pkg, rcts_if and all rcts_ modules.
//
//  channel  | direction | handshake        | beat carries
//  ---------+-----------+------------------+---------------------------------------
//  req_if   | in        | valid/ready      | texel load or pixel draw request
//  rsp_if   | out       | valid/ready      | shaded pixel (column, row, colour, region)
//  csr_*    | in        | csr_we only      | register index and write data
//
// One beat per cycle in and out while rsp_if is not stalled. A draw passes the front register,
// the queue, the queue output stage, the texel-row divider (one quotient bit per stage), the
// address stage and the result register. A load beat writes the texture store and yields no result.
// No clearing pass after reset. When rsp_if is stalled the back pipeline holds; the queue and
// front keep taking beats until the queue fills.
module raycast_column_texture_shader import rcts_pkg::*; #(
   parameter int TEX_MAX_DIM = TEX_MAX_DIM_DEF
) (
   input  logic                clock,
   input  logic                reset,
   rcts_req_if.sink            req_if,
   rcts_rsp_if.source          rsp_if,
   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [COLOR_W-1:0]  csr_wdata
);

   localparam int DIM_W = $clog2(TEX_MAX_DIM + 1);

   logic [COLOR_W-1:0]   ceiling_color_ff;
   logic [COLOR_W-1:0]   floor_color_ff;
   logic [CFG_DIM_W-1:0] tex_width_ff;
   logic [CFG_DIM_W-1:0] tex_height_ff;
   logic [DIM_W-1:0]     tw, th;

   logic    q_push, q_full, q_pop, q_empty;
   job_type q_job, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_color_ff <= '0;
         floor_color_ff   <= '0;
         tex_width_ff     <= CFG_DIM_W'(64);
         tex_height_ff    <= CFG_DIM_W'(64);
      end else if (csr_we) begin
         case (csr_index)
            CSR_CEILING_COLOR: ceiling_color_ff <= csr_wdata;
            CSR_FLOOR_COLOR:   floor_color_ff   <= csr_wdata;
            CSR_TEX_WIDTH:     tex_width_ff     <= csr_wdata[CFG_DIM_W-1:0];
            CSR_TEX_HEIGHT:    tex_height_ff    <= csr_wdata[CFG_DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp texture size into 1..TEX_MAX_DIM
   always_comb begin
      if (tex_width_ff == '0) begin
         tw = DIM_W'(1);
      end else if (int'(tex_width_ff) > TEX_MAX_DIM) begin
         tw = DIM_W'(TEX_MAX_DIM);
      end else begin
         tw = DIM_W'(tex_width_ff);
      end
      if (tex_height_ff == '0) begin
         th = DIM_W'(1);
      end else if (int'(tex_height_ff) > TEX_MAX_DIM) begin
         th = DIM_W'(TEX_MAX_DIM);
      end else begin
         th = DIM_W'(tex_height_ff);
      end
   end

   rcts_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (q_job)
   );

   rcts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   rcts_back #(
      .TEX_MAX_DIM (TEX_MAX_DIM)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .tw            (tw),
      .th            (th),
      .ceiling_color (ceiling_color_ff),
      .floor_color   (floor_color_ff),
      .rsp_if        (rsp_if)
   );

endmodule

@@ sim/rcts_pixel_monitor.sv @@
`timescale 1ns / 1ps
// Pixel monitor for the raycast column texture shader. It mirrors the registers and the
// texture store, predicts every shaded pixel and compares it with the result channel.
// Depends on rcts_pkg and the channel interfaces in rcts_if.
module rcts_pixel_monitor import rcts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   rcts_req_if                req_mon,
   rcts_rsp_if                rsp_mon,
   input  logic               csr_we,
   input  csr_index_type      csr_index,
   input  logic [COLOR_W-1:0] csr_wdata,
   output int                 in_flight,
   output int                 failures
);

   // keep the log readable when the block is badly broken
   localparam int REPORT_CAP = 100;

   logic [COLOR_W-1:0]   texels [STORE_DEPTH];
   logic [COLOR_W-1:0]   ceiling_rgb;
   logic [COLOR_W-1:0]   floor_rgb;
   logic [CFG_DIM_W-1:0] tex_w_cfg;
   logic [CFG_DIM_W-1:0] tex_h_cfg;
   rsp_type              pixels_due [$];
   int                   misses = 0;

   assign failures = misses;

   function automatic int unsigned usable_dim(input logic [CFG_DIM_W-1:0] cfg);
      if (cfg == 0) return 1;
      if (cfg > TEX_MAX_DIM_DEF) return TEX_MAX_DIM_DEF;
      return 32'(cfg);
   endfunction

   function automatic rsp_type shade_pixel(input req_type d);
      rsp_type     px;
      int unsigned w;
      int unsigned h;
      int unsigned tx;
      int unsigned ty;
      int unsigned lh;
      longint      num;
      longint      q;
      px.out_column = d.column;
      px.out_row    = d.row;
      if (d.row < d.span_start) begin
         px.pixel_color = ceiling_rgb;
         px.region      = REGION_CEILING;
      end else if (SPAN_END_W'(d.row) < d.span_end) begin
         w  = usable_dim(tex_w_cfg);
         h  = usable_dim(tex_h_cfg);
         tx = (32'(d.wall_frac) * w) >> FRAC_W;
         // mirror so the texture reads the same way from either face
         if ((!d.hit_side && d.dir_x_positive) || (d.hit_side && d.dir_y_negative))
            tx = w - 1 - tx;
         lh  = (d.wall_height == 0) ? 1 : 32'(d.wall_height);
         num = longint'(d.row) - longint'(SCREEN_HEIGHT / 2) + longint'(lh / 2);
         if (num < 0) begin
            ty = 0;
         end else begin
            q  = num * longint'(h) / longint'(lh);
            ty = (q >= longint'(h)) ? h - 1 : 32'(q);
         end
         px.pixel_color = texels[ADDR_W'(ty * w + tx)];
         px.region      = REGION_WALL;
      end else begin
         px.pixel_color = floor_rgb;
         px.region      = REGION_FLOOR;
      end
      return px;
   endfunction

   task automatic report(input string field, input logic [COLOR_W-1:0] want,
                         input logic [COLOR_W-1:0] got);
      misses++;
      if (misses <= REPORT_CAP)
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         ceiling_rgb = '0;
         floor_rgb   = '0;
         tex_w_cfg   = CFG_DIM_W'(64);
         tex_h_cfg   = CFG_DIM_W'(64);
         pixels_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CEILING_COLOR: ceiling_rgb = csr_wdata;
               CSR_FLOOR_COLOR:   floor_rgb   = csr_wdata;
               CSR_TEX_WIDTH:     tex_w_cfg   = csr_wdata[CFG_DIM_W-1:0];
               CSR_TEX_HEIGHT:    tex_h_cfg   = csr_wdata[CFG_DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.payload.cmd == CMD_LOAD)
               texels[req_mon.payload.texel_index] = req_mon.payload.texel_color;
            else
               pixels_due.push_back(shade_pixel(req_mon.payload));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (pixels_due.size() == 0) begin
               misses++;
               if (misses <= REPORT_CAP)
                  $display("%0t: expected no pixel, got column %0d row %0d colour %0h region %0d",
                           $time, got.out_column, got.out_row, got.pixel_color, got.region);
            end else begin
               want = pixels_due.pop_front();
               if (got.out_column != want.out_column)
                  report("out_column", 32'(want.out_column), 32'(got.out_column));
               if (got.out_row != want.out_row)
                  report("out_row", 32'(want.out_row), 32'(got.out_row));
               if (got.pixel_color != want.pixel_color)
                  report("pixel_color", want.pixel_color, got.pixel_color);
               if (got.region != want.region)
                  report("region", 32'(want.region), 32'(got.region));
            end
         end
      end
      in_flight <= pixels_due.size();
   end

endmodule

@@ sim/tb_raycast_column_texture_shader.sv @@
`timescale 1ns / 1ps
// Testbench top for the raycast column texture shader: clock, reset, request and register
// stimulus, result drain and the verdict. Prediction and checking live in rcts_pixel_monitor.
// Depends on rcts_pkg, rcts_if, the shader RTL and rcts_pixel_monitor.
module tb_raycast_column_texture_shader;
   import rcts_pkg::*;

   localparam int CLOCK_PERIOD    = 12;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 30;
   localparam int HOLD_CYCLES     = 300;
   localparam int BEATS_PER_PHASE = 120;
   localparam int PHASES          = 9;

   logic               clock;
   logic               reset;
   logic               csr_we;
   csr_index_type      csr_index;
   logic [COLOR_W-1:0] csr_wdata;
   int                 failures;
   int                 in_flight;
   int unsigned        cycles    = 0;
   bit                 idling    = 1'b1;
   bit                 hold_due  = 1'b0;
   bit                 written [STORE_DEPTH];
   int unsigned        tex_w     = 64;
   int unsigned        tex_h     = 64;

   rcts_req_if req_if();
   rcts_rsp_if rsp_if();

   raycast_column_texture_shader dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rcts_pixel_monitor pixel_monitor (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_if),
      .rsp_mon   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_flight (in_flight),
      .failures  (failures)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // mostly back to back, now and then a short pause, rarely a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned usable(input logic [COLOR_W-1:0] value);
      logic [CFG_DIM_W-1:0] cfg;
      cfg = value[CFG_DIM_W-1:0];
      if (cfg == 0) return 1;
      if (cfg > TEX_MAX_DIM_DEF) return TEX_MAX_DIM_DEF;
      return 32'(cfg);
   endfunction

   // store entry that a draw beat reads, when it lands on the wall
   function automatic bit wall_texel(input req_type d, output logic [ADDR_W-1:0] addr);
      int unsigned tx;
      int unsigned ty;
      int unsigned lh;
      longint      num;
      longint      q;
      addr = '0;
      if (d.cmd != CMD_SHADE || d.row < d.span_start || SPAN_END_W'(d.row) >= d.span_end)
         return 1'b0;
      tx = (32'(d.wall_frac) * tex_w) >> FRAC_W;
      if ((!d.hit_side && d.dir_x_positive) || (d.hit_side && d.dir_y_negative))
         tx = tex_w - 1 - tx;
      lh  = (d.wall_height == 0) ? 1 : 32'(d.wall_height);
      num = longint'(d.row) - longint'(SCREEN_HEIGHT / 2) + longint'(lh / 2);
      if (num < 0) begin
         ty = 0;
      end else begin
         q  = num * longint'(tex_h) / longint'(lh);
         ty = (q >= longint'(tex_h)) ? tex_h - 1 : 32'(q);
      end
      addr = ADDR_W'(ty * tex_w + tx);
      return 1'b1;
   endfunction

   function automatic req_type load_beat(input logic [ADDR_W-1:0] idx,
                                         input logic [COLOR_W-1:0] rgb);
      logic [127:0] noise;
      req_type      beat;
      noise            = {$urandom, $urandom, $urandom, $urandom};
      beat             = noise[$bits(req_type)-1:0];
      beat.cmd         = CMD_LOAD;
      beat.texel_index = idx;
      beat.texel_color = rgb;
      return beat;
   endfunction

   // sides packs {hit_side, dir_x_positive, dir_y_negative}
   function automatic req_type shade(input logic [ROW_W-1:0] row,
                                     input logic [ROW_W-1:0] first,
                                     input logic [SPAN_END_W-1:0] past,
                                     input logic [FRAC_W-1:0] frac,
                                     input logic [2:0] sides,
                                     input logic [LH_W-1:0] lh);
      req_type beat;
      beat                = load_beat(ADDR_W'($urandom), $urandom);
      beat.cmd            = CMD_SHADE;
      beat.row            = row;
      beat.span_start     = first;
      beat.span_end       = past;
      beat.wall_frac      = frac;
      beat.hit_side       = sides[2];
      beat.dir_x_positive = sides[1];
      beat.dir_y_negative = sides[0];
      beat.wall_height    = lh;
      return beat;
   endfunction

   function automatic req_type random_shade();
      logic [ROW_W-1:0]      row;
      logic [ROW_W-1:0]      first;
      logic [SPAN_END_W-1:0] past;
      logic [LH_W-1:0]       lh;
      int unsigned           pick;
      row  = ROW_W'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
         first = ROW_W'($urandom_range(0, row));
         if (pick == 0)
            past = SPAN_END_W'($urandom_range(row + 1, 1023));
         else
            past = SPAN_END_W'($urandom_range(row + 1, 512));
      end else if (pick < 15 && row < 9'd511) begin
         first = ROW_W'($urandom_range(row + 1, 511));
         past  = SPAN_END_W'($urandom);
      end else if (pick < 18) begin
         first = ROW_W'($urandom_range(0, row));
         past  = SPAN_END_W'($urandom_range(0, row));
      end else begin
         first = ROW_W'($urandom);
         past  = SPAN_END_W'($urandom);
      end
      pick = $urandom_range(0, 19);
      if (pick == 0)
         lh = '0;
      else if (pick < 4)
         lh = LH_W'($urandom_range(1, 16383));
      else
         lh = LH_W'($urandom_range(1, 1024));
      return shade(row, first, past, FRAC_W'($urandom), 3'($urandom), lh);
   endfunction

   task automatic push_beat(input req_type beat);
      int g;
      g = idling ? pick_gap() : 0;
      if (g > 0) begin
         req_if.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= beat;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // load the texel a draw will read first, so no draw ever reads an unwritten entry
   task automatic send(input req_type beat);
      logic [ADDR_W-1:0] addr;
      bit                hit;
      if (beat.cmd == CMD_LOAD) begin
         written[beat.texel_index] = 1'b1;
      end else begin
         hit = wall_texel(beat, addr);
         if (hit && !written[addr]) begin
            written[addr] = 1'b1;
            push_beat(load_beat(addr, $urandom));
         end
      end
      push_beat(beat);
   endtask

   // drop valid, let every pixel come back, then give loads time to retire
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [COLOR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [COLOR_W-1:0] ceil_rgb, input logic [COLOR_W-1:0] flr_rgb,
                            input logic [COLOR_W-1:0] w, input logic [COLOR_W-1:0] h);
      settle();
      write_reg(CSR_CEILING_COLOR, ceil_rgb);
      write_reg(CSR_FLOOR_COLOR, flr_rgb);
      write_reg(CSR_TEX_WIDTH, w);
      write_reg(CSR_TEX_HEIGHT, h);
      csr_we <= 1'b0;
      tex_w = usable(w);
      tex_h = usable(h);
   endtask

   initial begin : drain
      int g;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_due) begin
            // long hold-off so the queue fills and the input stalls
            hold_due = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         g = idling ? pick_gap() : 0;
         if (g > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin : stimulus
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_CEILING_COLOR;
      csr_wdata      <= '0;
      reset          <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed beats under the reset register values
      send(load_beat(12'h000, 32'hFFFF_FFFF));
      send(load_beat(12'hFFF, 32'h0000_0000));
      send(shade(9'd0,   9'd1, 10'd512, 16'h8000, 3'b000, 14'd64));
      send(shade(9'd511, 9'd0, 10'd511, 16'h8000, 3'b000, 14'd64));
      send(shade(9'd256, 9'd0, 10'd512, 16'h0000, 3'b010, 14'd64));
      send(shade(9'd256, 9'd0, 10'd512, 16'h0000, 3'b001, 14'd64));
      send(shade(9'd256, 9'd0, 10'd512, 16'h0000, 3'b101, 14'd64));
      send(shade(9'd256, 9'd0, 10'd512, 16'h0000, 3'b110, 14'd64));
      send(shade(9'd300, 9'd0, 10'd512, 16'hFFFF, 3'b000, 14'd100));
      send(shade(9'd300, 9'd0, 10'd512, 16'hFFFF, 3'b111, 14'd100));
      send(shade(9'd200, 9'd0, 10'd512, 16'h1234, 3'b000, 14'd0));
      send(shade(9'd200, 9'd0, 10'd512, 16'h4321, 3'b000, 14'h3FFF));
      // texel row clamps at the bottom and reads the last store entry
      send(shade(9'd511, 9'd0, 10'd512, 16'hFFFF, 3'b000, 14'd1));
      // negative numerator, first store entry
      send(shade(9'd0, 9'd0, 10'd512, 16'h0000, 3'b000, 14'd2));
      // empty and inverted spans
      send(shade(9'd100, 9'd100, 10'd100, 16'h5555, 3'b000, 14'd40));
      send(shade(9'd200, 9'd300, 10'd100, 16'hAAAA, 3'b000, 14'd40));
      send(shade(9'd350, 9'd300, 10'd100, 16'hAAAA, 3'b000, 14'd40));
      send(shade(9'd511, 9'd511, 10'd1023, 16'hABCD, 3'b110, 14'd600));

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: configure(32'hFFFF_FFFF, 32'h0000_0000, 32'd1, 32'd1);
            1: configure(32'h0000_0000, 32'hFFFF_FFFF, 32'd64, 32'd1);
            2: configure($urandom, $urandom, 32'd1, 32'd64);
            3: configure($urandom, $urandom, 32'd64, 32'd64);
            // zero acts as one texel
            4: configure($urandom, $urandom, 32'd0, 32'd0);
            // all ones masks to 127, which saturates at the maximum size
            5: configure($urandom, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            6: configure($urandom, $urandom, 32'd100, 32'd65);
            default: configure($urandom, $urandom, $urandom_range(1, 64), $urandom_range(1, 64));
         endcase
         idling = !(p == 3 || p == 6);
         if (p == 3)
            hold_due = 1'b1;
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            if ($urandom_range(0, 4) == 0)
               send(load_beat(ADDR_W'($urandom), $urandom));
            else
               send(random_shade());
         end
      end

      settle();
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ raycast_column_texture_shader.f @@
hw/rtl/rcts_pkg.sv
hw/rtl/rcts_if.sv
hw/rtl/rcts_ram.sv
hw/rtl/rcts_queue.sv
hw/rtl/rcts_front.sv
hw/rtl/rcts_back.sv
hw/rtl/raycast_column_texture_shader.sv
sim/rcts_pixel_monitor.sv
sim/tb_raycast_column_texture_shader.sv
